>>> rtl/hpm_pkg.sv
// Shared types, constants and arithmetic helpers for the heading PD thruster mixer.
`timescale 1ns / 1ps

package hpm_pkg;

  // angle, error and drive formats
  localparam int ANG_W      = 15;
  localparam int ERR_W      = 25;
  localparam int PD_W       = 15;
  localparam int MOT_W      = 16;
  localparam int PULSE_W    = 15;
  localparam int HIST_DEPTH = 3;

  // shared multiplier and divider widths
  localparam int MUL_A_W  = 40;
  localparam int MUL_B_W  = 17;
  localparam int PROD_W   = 50;
  localparam int DIV_N_W  = 50;
  localparam int DIV_D_W  = 44;
  localparam int ACC_W    = 51;

  // configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // arithmetic constants
  localparam int ANG_FULL      = 23040;
  localparam int ANG_HALF      = 11520;
  localparam int PD_LIMIT      = 12800;
  localparam int CMD_LIMIT     = 100;
  localparam int K_RATE_SCALE  = 8000;
  localparam int K_TRPM        = 6144;
  localparam int K_TRPM_DIV    = 100;
  localparam int K_DERIV       = 1000;
  localparam int K_TURN_DIV    = 180;
  localparam int K_FILT_DIV    = 5;
  localparam int MIN_DT        = 10;
  localparam int RATE_SHIFT    = 12;
  localparam int HEAD_SHIFT    = 8;
  localparam int PULSE_MID     = 24000;
  localparam int PULSE_MARGIN  = 400;
  localparam int DEAD_BAND     = 32;

  // reciprocals for the constant divisions, exact over the operand ranges used
  localparam int unsigned R5_MUL     = 52429;
  localparam int unsigned R5_SHIFT   = 18;
  localparam int unsigned R100_MUL   = 671089;
  localparam int unsigned R100_SHIFT = 26;
  localparam int unsigned R180_MUL   = 11651;
  localparam int unsigned R180_SHIFT = 21;

  typedef logic signed [ANG_W-1:0] ang_t;
  typedef logic signed [ERR_W-1:0] err_t;
  typedef logic signed [PD_W-1:0]  pd_t;
  typedef logic signed [MOT_W-1:0] mot_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 4'd0,
    REG_PID       = 4'd1,
    REG_LOCK      = 4'd2,
    REG_EMERGENCY = 4'd3,
    REG_RATE_KP   = 4'd4,
    REG_RATE_KD   = 4'd5,
    REG_HEAD_KP   = 4'd6,
    REG_HEAD_KD   = 4'd7
  } cfg_reg_t;

  localparam logic [1:0] MODE_SINGLE = 2'd0;
  localparam logic [1:0] MODE_PAIR   = 2'd1;

  // divider status seen by the sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } div_rsp_t;

  // wrap into (-ANG_HALF, ANG_HALF]; valid for |v| < 2*ANG_FULL
  function automatic ang_t wrap_ang(input logic signed [17:0] v);
    logic signed [17:0] m;
    begin
      m = v;
      if (m < -18'sd23040)    m = m + 18'sd46080;
      else if (m < 18'sd0)    m = m + 18'sd23040;
      else if (m >= 18'sd23040) m = m - 18'sd23040;
      if (m > 18'sd11520)     m = m - 18'sd23040;
      return ANG_W'(m);
    end
  endfunction

  function automatic logic signed [7:0] clamp_cmd(input logic signed [7:0] v);
    begin
      if (v > 8'sd100)       return 8'sd100;
      else if (v < -8'sd100) return -8'sd100;
      else                   return v;
    end
  endfunction

  // round to nearest by 2**k, ties away from zero
  function automatic logic signed [ACC_W-1:0] rdiv_p2(input logic signed [ACC_W-1:0] n,
                                                      input int unsigned k);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] q;
    begin
      mag = n[ACC_W-1] ? $unsigned(-n) : $unsigned(n);
      q   = (mag + (ACC_W'(1) << (k - 1))) >> k;
      return n[ACC_W-1] ? -$signed(q) : $signed(q);
    end
  endfunction

  // round to nearest by a constant divisor through its reciprocal, ties away from zero
  function automatic logic signed [23:0] rdiv_rcp(input logic signed [23:0] n,
                                                  input int unsigned half,
                                                  input int unsigned mul,
                                                  input int unsigned shift);
    logic [23:0] mag;
    logic [47:0] prod;
    begin
      mag  = n[23] ? $unsigned(-n) : $unsigned(n);
      prod = (48'(mag) + 48'(half)) * 48'(mul);
      prod = prod >> shift;
      return n[23] ? -$signed(24'(prod)) : $signed(24'(prod));
    end
  endfunction

  function automatic pd_t clamp_pd(input logic signed [ACC_W-1:0] v);
    begin
      if (v > ACC_W'(PD_LIMIT))       return PD_W'(PD_LIMIT);
      else if (v < -ACC_W'(PD_LIMIT)) return -PD_W'(PD_LIMIT);
      else                            return PD_W'(v);
    end
  endfunction

  function automatic logic [PULSE_W-1:0] pulse_of(input mot_t m);
    logic signed [ACC_W-1:0] r;
    logic signed [ACC_W-1:0] margin;
    begin
      r = rdiv_p2(ACC_W'(m), 2);
      if (m > -MOT_W'(DEAD_BAND) && m < MOT_W'(DEAD_BAND)) margin = '0;
      else if (m > 0) margin = ACC_W'(PULSE_MARGIN);
      else            margin = -ACC_W'(PULSE_MARGIN);
      return PULSE_W'(ACC_W'(PULSE_MID) + r + margin);
    end
  endfunction

endpackage

>>> rtl/hpm_if.sv
// Poll and pulse stream channel interfaces.
`timescale 1ns / 1ps

interface hpm_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] north_angle;
  logic [31:0]        time_ms;
  logic signed [7:0]  thrust_cmd;
  logic signed [7:0]  rudder_cmd;
  logic signed [15:0] target_heading;

  modport source (output valid, north_angle, time_ms, thrust_cmd, rudder_cmd,
                  target_heading, input ready);
  modport sink   (input valid, north_angle, time_ms, thrust_cmd, rudder_cmd,
                  target_heading, output ready);
endinterface

interface hpm_out_if;
  logic        valid;
  logic        ready;
  logic [14:0] pulse_front_right;
  logic [14:0] pulse_front_left;
  logic [14:0] pulse_rear_right;
  logic [14:0] pulse_rear_left;
  logic        loop_updated;

  modport source (output valid, pulse_front_right, pulse_front_left, pulse_rear_right,
                  pulse_rear_left, loop_updated, input ready);
  modport sink   (input valid, pulse_front_right, pulse_front_left, pulse_rear_right,
                  pulse_rear_left, loop_updated, output ready);
endinterface

>>> rtl/hpm_rdiv.sv
// Shared radix-2 rounding divider: signed numerator, positive divisor.
`timescale 1ns / 1ps

module hpm_rdiv #(
  parameter int N_W = hpm_pkg::DIV_N_W,
  parameter int D_W = hpm_pkg::DIV_D_W
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic signed [N_W-1:0] num,
  input  logic [D_W-1:0]        den,
  output hpm_pkg::div_rsp_t     rsp,
  output logic signed [N_W-1:0] quo
);

  localparam int CNT_W = $clog2(N_W + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   mag_r;
  logic [D_W-1:0]   rem_r;
  logic [D_W-1:0]   den_r;
  logic             neg_r;

  logic [D_W:0]     rem_sh;
  logic             ge;
  logic [N_W-1:0]   abs_num;

  assign abs_num = num[N_W-1] ? $unsigned(-num) : $unsigned(num);
  assign rem_sh  = {rem_r, mag_r[N_W-1]};
  assign ge      = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(N_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // bias by half the divisor, then shift one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      mag_r <= abs_num + N_W'(den >> 1);
      rem_r <= '0;
      den_r <= den;
      neg_r <= num[N_W-1];
    end else if (busy_r) begin
      rem_r <= ge ? D_W'(rem_sh - {1'b0, den_r}) : rem_sh[D_W-1:0];
      mag_r <= {mag_r[N_W-2:0], ge};
    end
  end

  assign quo      = neg_r ? -$signed(mag_r) : $signed(mag_r);
  assign rsp.busy = busy_r;
  assign rsp.done = done_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a pass");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0 && cnt_r <= CNT_W'(N_W))) else $error("divider count out of range");

endmodule

>>> rtl/heading_pd_thruster_mixer.sv
// Top level: heading PD controller with differential thrust mixing.
//
//  channel  | dir | handshake       | word
//  ---------+-----+-----------------+------------------------------------------------
//  in_ch    | in  | valid / ready   | north_angle, time_ms, thrust_cmd, rudder_cmd,
//           |     |                 | target_heading
//  out_ch   | out | valid / ready   | four pulse widths, loop_updated
//  cfg_*    | in  | cfg_we          | cfg_index selects register, cfg_wdata value
//
// Arithmetic: a full closed-loop step runs four divides by the elapsed time on the shared
// radix-2 divider, plus multiplier and sequencing steps; while the history is still
// filling it runs only the two rate divides. Divisions by constants use combinational
// reciprocal multiplies.
// Reset: rst_n synchronous, active low; restores register defaults, clears state.
// Stalls: a finished word waits in the output register; the sequencer holds in
// its output step until that register is free, and in_ch.ready is high only idle.
`timescale 1ns / 1ps

module heading_pd_thruster_mixer #(
  parameter int HISTORY_DEPTH = hpm_pkg::HIST_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  hpm_in_if.sink                            in_ch,
  hpm_out_if.source                         out_ch,
  input  logic                              cfg_we,
  input  logic [hpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int MA     = hpm_pkg::MUL_A_W;
  localparam int MB     = hpm_pkg::MUL_B_W;
  localparam int PW     = hpm_pkg::PROD_W;
  localparam int DN     = hpm_pkg::DIV_N_W;
  localparam int DD     = hpm_pkg::DIV_D_W;
  localparam int AW     = hpm_pkg::ACC_W;

  typedef enum logic [20:0] {
    ST_IDLE     = 21'b1 << 0,
    ST_DISP     = 21'b1 << 1,
    ST_OPEN     = 21'b1 << 2,
    ST_FAST     = 21'b1 << 3,
    ST_SLOW     = 21'b1 << 4,
    ST_RF_MUL   = 21'b1 << 5,
    ST_RF_DIV   = 21'b1 << 6,
    ST_RS_MUL   = 21'b1 << 7,
    ST_RS_DIV   = 21'b1 << 8,
    ST_TRPM     = 21'b1 << 9,
    ST_ERR      = 21'b1 << 10,
    ST_P0_MUL   = 21'b1 << 11,
    ST_D0_MUL1  = 21'b1 << 12,
    ST_D0_MUL2  = 21'b1 << 13,
    ST_D0_DIV   = 21'b1 << 14,
    ST_P1_MUL   = 21'b1 << 15,
    ST_D1_MUL1  = 21'b1 << 16,
    ST_D1_MUL2  = 21'b1 << 17,
    ST_D1_DIV   = 21'b1 << 18,
    ST_MIX      = 21'b1 << 19,
    ST_OUT      = 21'b1 << 20
  } state_t;

  state_t state_r, state_nxt;

  // configuration registers
  logic [1:0]         mode_r;
  logic               pid_r, lock_r, emerg_r;
  logic signed [15:0] rkp_r, rkd_r, hkp_r, hkd_r;

  // loop state
  logic [31:0]         last_time_r;
  logic                tv_r, fv_r;
  hpm_pkg::ang_t       hf_r, hs_r, phf_r, phs_r;
  hpm_pkg::err_t       h1_r;
  hpm_pkg::ang_t       h3_r;
  logic [FILL_W-1:0]   fill_r;
  hpm_pkg::pd_t        pd0_r, pd1_r;
  hpm_pkg::mot_t       mot_r [4];

  // per-word working registers
  logic [31:0]         t_r;
  logic signed [7:0]   thr_r, rud_r;
  hpm_pkg::ang_t       tgt_r, head_r;
  hpm_pkg::err_t       rf_r, rs_r, e0_r, e1_r, trpm_r;
  hpm_pkg::ang_t       e2_r, e3_r;
  logic signed [PW-1:0] p_r;
  logic signed [PW-1:0] prod_r;
  logic                run_r, upd_r, issued_r;

  // output register
  logic                  out_valid_r;
  logic [14:0]           o_fr_r, o_fl_r, o_rr_r, o_rl_r;
  logic                  o_upd_r;

  // shared units
  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic                  div_start, is_div;
  logic signed [DN-1:0]  div_num, div_quo;
  logic [DD-1:0]         div_den;
  hpm_pkg::div_rsp_t     div_rsp;

  logic [31:0]           dt;
  hpm_pkg::mot_t         mix_a, mix_b, open_a, open_b;
  logic signed [AW-1:0]  val, thr64;
  logic signed [23:0]    turn, fast_q, slow_q, trpm_q;

  // last_time_r advances only when the step ends, so dt holds through the divides
  assign dt = t_r - last_time_r;

  hpm_rdiv #(.N_W(DN), .D_W(DD)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .rsp   (div_rsp),
    .quo   (div_quo)
  );

  // multiplier operand select; the product is registered in prod_r
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_RF_MUL: begin
        mul_a = MA'(hpm_pkg::wrap_ang(18'(hf_r) - 18'(phf_r)));
        mul_b = MB'(hpm_pkg::K_RATE_SCALE);
      end
      ST_RS_MUL: begin
        mul_a = MA'(hpm_pkg::wrap_ang(18'(hs_r) - 18'(phs_r)));
        mul_b = MB'(hpm_pkg::K_RATE_SCALE);
      end
      ST_P0_MUL: begin
        mul_a = MA'(e0_r);
        mul_b = MB'(rkp_r);
      end
      ST_D0_MUL1: begin
        mul_a = MA'(e1_r) - MA'(h1_r);
        mul_b = MB'(rkd_r);
      end
      ST_P1_MUL: begin
        mul_a = MA'(e2_r);
        mul_b = MB'(hkp_r);
      end
      ST_D1_MUL1: begin
        mul_a = MA'(hpm_pkg::wrap_ang(18'(e3_r) - 18'(h3_r)));
        mul_b = MB'(hkd_r);
      end
      ST_D0_MUL2, ST_D1_MUL2: begin
        mul_a = MA'(prod_r);
        mul_b = MB'(hpm_pkg::K_DERIV);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= PW'(mul_a * mul_b);
  end

  // divider operand select; issue once on entry to each divide step
  always_comb begin
    div_num = '0;
    div_den = DD'(1);
    case (state_r)
      ST_RF_DIV, ST_RS_DIV: begin
        div_num = prod_r;
        div_den = DD'(dt) + (DD'(dt) << 1);
      end
      ST_D0_DIV: begin
        div_num = prod_r;
        div_den = DD'(dt) << hpm_pkg::RATE_SHIFT;
      end
      ST_D1_DIV: begin
        div_num = prod_r;
        div_den = DD'(dt) << hpm_pkg::HEAD_SHIFT;
      end
      default: begin
        div_num = '0;
        div_den = DD'(1);
      end
    endcase
    is_div    = state_r inside {ST_RF_DIV, ST_RS_DIV, ST_D0_DIV, ST_D1_DIV};
    div_start = is_div && !issued_r;
  end

  // divisions by constants: filter gains, turn rate target, open-loop turn
  always_comb begin
    turn   = hpm_pkg::rdiv_rcp(24'(tgt_r), hpm_pkg::K_TURN_DIV / 2,
                               hpm_pkg::R180_MUL, hpm_pkg::R180_SHIFT);
    fast_q = hpm_pkg::rdiv_rcp(24'(hpm_pkg::wrap_ang(18'(head_r) - 18'(hf_r))) <<< 2,
                               hpm_pkg::K_FILT_DIV / 2, hpm_pkg::R5_MUL,
                               hpm_pkg::R5_SHIFT);
    slow_q = hpm_pkg::rdiv_rcp(24'(hpm_pkg::wrap_ang(18'(head_r) - 18'(hs_r))),
                               hpm_pkg::K_FILT_DIV / 2, hpm_pkg::R5_MUL,
                               hpm_pkg::R5_SHIFT);
    trpm_q = hpm_pkg::rdiv_rcp(24'(rud_r) * 24'(hpm_pkg::K_TRPM), hpm_pkg::K_TRPM_DIV / 2,
                               hpm_pkg::R100_MUL, hpm_pkg::R100_SHIFT);
  end

  // motor mixing arithmetic
  always_comb begin
    thr64 = AW'(thr_r) * 64;
    val   = lock_r ? AW'(pd1_r) : AW'(pd0_r);
    if (mode_r == hpm_pkg::MODE_SINGLE) begin
      mix_a = hpm_pkg::MOT_W'(hpm_pkg::rdiv_p2(AW'(mot_r[0]) + thr64, 1));
      mix_b = hpm_pkg::MOT_W'(hpm_pkg::rdiv_p2(AW'(mot_r[1]) + val, 1));
    end else begin
      mix_a = hpm_pkg::MOT_W'(hpm_pkg::rdiv_p2(AW'(mot_r[0]) * 2 + thr64 * 2 + val, 2));
      mix_b = hpm_pkg::MOT_W'(hpm_pkg::rdiv_p2(AW'(mot_r[1]) * 2 + thr64 * 2 - val, 2));
    end
    open_a = hpm_pkg::MOT_W'(thr64 + AW'(turn));
    open_b = hpm_pkg::MOT_W'(thr64 - AW'(turn));
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_ch.valid) state_nxt = ST_DISP;
      ST_DISP: begin
        if (!pid_r) begin
          state_nxt = (mode_r == hpm_pkg::MODE_PAIR) ? ST_OPEN : ST_OUT;
        end else if (mode_r != hpm_pkg::MODE_SINGLE && mode_r != hpm_pkg::MODE_PAIR) begin
          state_nxt = ST_OUT;
        end else if (!tv_r || dt < 32'(hpm_pkg::MIN_DT) || !fv_r) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_FAST;
        end
      end
      ST_OPEN:     state_nxt = ST_OUT;
      ST_FAST:     state_nxt = ST_SLOW;
      ST_SLOW:     state_nxt = ST_RF_MUL;
      ST_RF_MUL:   state_nxt = ST_RF_DIV;
      ST_RF_DIV:   if (div_rsp.done) state_nxt = ST_RS_MUL;
      ST_RS_MUL:   state_nxt = ST_RS_DIV;
      ST_RS_DIV:   if (div_rsp.done) state_nxt = ST_TRPM;
      ST_TRPM:     state_nxt = ST_ERR;
      ST_ERR:      state_nxt = (fill_r >= FILL_W'(2)) ? ST_P0_MUL : ST_MIX;
      ST_P0_MUL:   state_nxt = ST_D0_MUL1;
      ST_D0_MUL1:  state_nxt = ST_D0_MUL2;
      ST_D0_MUL2:  state_nxt = ST_D0_DIV;
      ST_D0_DIV:   if (div_rsp.done) state_nxt = ST_P1_MUL;
      ST_P1_MUL:   state_nxt = ST_D1_MUL1;
      ST_D1_MUL1:  state_nxt = ST_D1_MUL2;
      ST_D1_MUL2:  state_nxt = ST_D1_DIV;
      ST_D1_DIV:   if (div_rsp.done) state_nxt = ST_MIX;
      ST_MIX:      state_nxt = ST_OUT;
      ST_OUT:      if (!out_valid_r || out_ch.ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= hpm_pkg::MODE_PAIR;
      pid_r       <= 1'b0;
      lock_r      <= 1'b1;
      emerg_r     <= 1'b0;
      rkp_r       <= 16'sd256;
      rkd_r       <= '0;
      hkp_r       <= 16'sd256;
      hkd_r       <= '0;
      last_time_r <= '0;
      tv_r        <= 1'b0;
      fv_r        <= 1'b0;
      hf_r        <= '0;
      hs_r        <= '0;
      phf_r       <= '0;
      phs_r       <= '0;
      h1_r        <= '0;
      h3_r        <= '0;
      fill_r      <= '0;
      pd0_r       <= '0;
      pd1_r       <= '0;
      for (int i = 0; i < 4; i++) mot_r[i] <= '0;
      issued_r    <= 1'b0;
      run_r       <= 1'b0;
      upd_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // configuration writes must arrive only while idle; the block itself does not enforce it
      if (cfg_we) begin
        case (cfg_index)
          hpm_pkg::REG_MODE:      mode_r  <= cfg_wdata[1:0];
          hpm_pkg::REG_PID: begin
            pid_r  <= cfg_wdata[0];
            h1_r   <= '0;
            h3_r   <= '0;
            fill_r <= '0;
            pd0_r  <= '0;
            pd1_r  <= '0;
          end
          hpm_pkg::REG_LOCK:      lock_r  <= cfg_wdata[0];
          hpm_pkg::REG_EMERGENCY: emerg_r <= cfg_wdata[0];
          hpm_pkg::REG_RATE_KP:   rkp_r   <= $signed(cfg_wdata);
          hpm_pkg::REG_RATE_KD:   rkd_r   <= $signed(cfg_wdata);
          hpm_pkg::REG_HEAD_KP:   hkp_r   <= $signed(cfg_wdata);
          hpm_pkg::REG_HEAD_KD:   hkd_r   <= $signed(cfg_wdata);
          default: ;
        endcase
      end

      // one issue per divide step
      if (div_start)         issued_r <= 1'b1;
      else if (div_rsp.done) issued_r <= 1'b0;

      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_ch.valid) begin
            t_r    <= in_ch.time_ms;
            thr_r  <= hpm_pkg::clamp_cmd(in_ch.thrust_cmd);
            rud_r  <= hpm_pkg::clamp_cmd(in_ch.rudder_cmd);
            tgt_r  <= hpm_pkg::wrap_ang(18'(in_ch.target_heading));
            head_r <= hpm_pkg::wrap_ang(-18'(in_ch.north_angle));
          end
        end
        ST_DISP: begin
          upd_r <= 1'b0;
          if (!pid_r) begin
            if (mode_r == hpm_pkg::MODE_SINGLE) begin
              mot_r[0] <= hpm_pkg::MOT_W'(thr64);
              mot_r[1] <= hpm_pkg::MOT_W'(AW'(rud_r) * 64);
            end
          end else if (mode_r == hpm_pkg::MODE_SINGLE || mode_r == hpm_pkg::MODE_PAIR) begin
            if (!tv_r) begin
              // first closed-loop word only latches the time
              last_time_r <= t_r;
              tv_r        <= 1'b1;
            end else if (dt >= 32'(hpm_pkg::MIN_DT)) begin
              if (!fv_r) begin
                last_time_r <= t_r;
                hf_r  <= head_r;
                hs_r  <= head_r;
                phf_r <= head_r;
                phs_r <= head_r;
                fv_r  <= 1'b1;
              end
            end
          end
        end
        ST_OPEN: begin
          if (emerg_r) begin
            mot_r[0] <= '0;
            mot_r[1] <= '0;
            mot_r[2] <= open_a;
            mot_r[3] <= open_b;
          end else begin
            mot_r[0] <= open_a;
            mot_r[1] <= open_b;
            mot_r[2] <= '0;
            mot_r[3] <= '0;
          end
        end
        ST_FAST:     hf_r <= hpm_pkg::wrap_ang(18'(hf_r) + 18'(fast_q));
        ST_SLOW:     hs_r <= hpm_pkg::wrap_ang(18'(hs_r) + 18'(slow_q));
        ST_RF_DIV:   if (div_rsp.done) rf_r <= hpm_pkg::ERR_W'(div_quo);
        ST_RS_DIV:   if (div_rsp.done) rs_r <= hpm_pkg::ERR_W'(div_quo);
        ST_TRPM:     trpm_r <= hpm_pkg::ERR_W'(trpm_q);
        ST_ERR: begin
          e0_r  <= rf_r - trpm_r;
          e1_r  <= rs_r - trpm_r;
          e2_r  <= hpm_pkg::wrap_ang(18'(hf_r) - 18'(tgt_r));
          e3_r  <= hpm_pkg::wrap_ang(18'(hs_r) - 18'(tgt_r));
          phf_r <= hf_r;
          phs_r <= hs_r;
          run_r <= fill_r >= FILL_W'(2);
        end
        ST_D0_MUL1: p_r <= PW'(hpm_pkg::rdiv_p2(AW'(prod_r), hpm_pkg::RATE_SHIFT));
        ST_D0_DIV:  if (div_rsp.done) pd0_r <= hpm_pkg::clamp_pd(AW'(p_r) + AW'(div_quo));
        ST_D1_MUL1: p_r <= PW'(hpm_pkg::rdiv_p2(AW'(prod_r), hpm_pkg::HEAD_SHIFT));
        ST_D1_DIV:  if (div_rsp.done) pd1_r <= hpm_pkg::clamp_pd(AW'(p_r) + AW'(div_quo));
        ST_MIX: begin
          // close the step; push the newest errors, only the head row is read back
          last_time_r <= t_r;
          h1_r <= e1_r;
          h3_r <= e3_r;
          if (fill_r < FILL_W'(HISTORY_DEPTH)) fill_r <= fill_r + 1'b1;
          if (run_r) begin
            upd_r <= 1'b1;
            if (mode_r == hpm_pkg::MODE_SINGLE) begin
              mot_r[0] <= mix_a;
              mot_r[1] <= mix_b;
            end else if (emerg_r) begin
              mot_r[0] <= '0;
              mot_r[1] <= '0;
              mot_r[2] <= mix_a;
              mot_r[3] <= mix_b;
            end else begin
              mot_r[0] <= mix_a;
              mot_r[1] <= mix_b;
              mot_r[2] <= '0;
              mot_r[3] <= '0;
            end
          end
        end
        ST_OUT: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            o_fr_r      <= hpm_pkg::pulse_of(mot_r[0]);
            o_fl_r      <= hpm_pkg::pulse_of(mot_r[1]);
            o_rr_r      <= hpm_pkg::pulse_of(mot_r[2]);
            o_rl_r      <= hpm_pkg::pulse_of(mot_r[3]);
            o_upd_r     <= upd_r;
          end
        end
        default: ;
      endcase
    end
  end

  assign in_ch.ready              = (state_r == ST_IDLE);
  assign out_ch.valid             = out_valid_r;
  assign out_ch.pulse_front_right = o_fr_r;
  assign out_ch.pulse_front_left  = o_fl_r;
  assign out_ch.pulse_rear_right  = o_rr_r;
  assign out_ch.pulse_rear_left   = o_rl_r;
  assign out_ch.loop_updated      = o_upd_r;

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> state_r == ST_DISP)
    else $error("accepted word not dispatched");
  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while idle");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill overflow");
  a_pd_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (pd0_r <= hpm_pkg::PD_W'(hpm_pkg::PD_LIMIT)) && (pd0_r >= -hpm_pkg::PD_W'(hpm_pkg::PD_LIMIT))
    && (pd1_r <= hpm_pkg::PD_W'(hpm_pkg::PD_LIMIT))
    && (pd1_r >= -hpm_pkg::PD_W'(hpm_pkg::PD_LIMIT)))
    else $error("PD output beyond limit");
  a_update_needs_loop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MIX && run_r) |-> pid_r)
    else $error("loop update outside closed loop");

endmodule

>>> sim/heading_pd_thruster_mixer_tb.sv
// Self-checking testbench for the heading PD controller with thruster mixing.
`timescale 1ns / 1ps

module heading_pd_thruster_mixer_tb;
  import hpm_pkg::*;

  localparam longint CYCLE_LIMIT = 1500000;
  localparam int     DRAIN_CYCLES = 500;

  typedef struct {
    logic signed [15:0] north;
    logic [31:0]        tms;
    logic signed [7:0]  thr;
    logic signed [7:0]  rud;
    logic signed [15:0] tgt;
  } poll_t;

  typedef struct {
    logic [14:0] fr;
    logic [14:0] fl;
    logic [14:0] rr;
    logic [14:0] rl;
    logic        upd;
  } pulses_t;

  // Scoreboard: carries its own copy of the controller state and the queue
  // of pulse words it expects, oldest first.
  class mixer_scoreboard;
    int unsigned mode, pid, lock, emerg;
    longint rkp, rkd, hkp, hkd;
    logic [31:0] last_t;
    bit t_ok, f_ok;
    longint hf, hs, phf, phs;
    longint last_e1, last_e3;
    int unsigned fill;
    longint pd0, pd1;
    longint mv[4];
    pulses_t pending_pulses[$];
    int errors;

    function new();
      errors = 0;
      clear();
    endfunction

    function void clear();
      mode = MODE_PAIR; pid = 0; lock = 1; emerg = 0;
      rkp = 256; rkd = 0; hkp = 256; hkd = 0;
      last_t = '0; t_ok = 0; f_ok = 0;
      hf = 0; hs = 0; phf = 0; phs = 0;
      last_e1 = 0; last_e3 = 0; fill = 0; pd0 = 0; pd1 = 0;
      foreach (mv[i]) mv[i] = 0;
    endfunction

    static function longint rnd(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
    endfunction

    static function longint wrp(longint v);
      longint m;
      m = v % ANG_FULL;
      if (m < 0) m += ANG_FULL;
      if (m > ANG_HALF) m -= ANG_FULL;
      return m;
    endfunction

    static function longint sat(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    static function logic [14:0] width_of(longint m);
      longint margin;
      margin = (m > -32 && m < 32) ? 0 : (m > 0 ? 400 : -400);
      return 15'(24000 + rnd(m, 4) + margin);
    endfunction

    function void drive(longint r, longint l);
      if (emerg != 0) begin
        mv[0] = 0; mv[1] = 0; mv[2] = r; mv[3] = l;
      end else begin
        mv[0] = r; mv[1] = l; mv[2] = 0; mv[3] = 0;
      end
    endfunction

    function void config_write(logic [3:0] idx, logic [15:0] d);
      case (idx)
        REG_MODE:      mode = d[1:0];
        REG_PID: begin
          pid = d[0]; last_e1 = 0; last_e3 = 0; fill = 0; pd0 = 0; pd1 = 0;
        end
        REG_LOCK:      lock = d[0];
        REG_EMERGENCY: emerg = d[0];
        REG_RATE_KP:   rkp = longint'($signed(d));
        REG_RATE_KD:   rkd = longint'($signed(d));
        REG_HEAD_KP:   hkp = longint'($signed(d));
        REG_HEAD_KD:   hkd = longint'($signed(d));
        default: ;
      endcase
    endfunction

    function bit loop_step(logic [31:0] t, longint north, longint thr, longint rud,
                           longint tgt);
      longint dt, hd, d, rf, rs, trpm, e0, e1, e2, e3, p, dd, val, r, l;
      logic [31:0] diff;
      bit run;
      if (!t_ok) begin
        last_t = t; t_ok = 1; return 0;
      end
      diff = t - last_t;
      dt = longint'({32'b0, diff});
      if (dt < MIN_DT) return 0;
      last_t = t;
      hd = wrp(-north);
      if (!f_ok) begin
        hf = hd; hs = hd; phf = hd; phs = hd; f_ok = 1; return 0;
      end
      d = wrp(hd - hf);
      hf = wrp(hf + rnd(d * 4, 5));
      d = wrp(hd - hs);
      hs = wrp(hs + rnd(d, 5));
      rf = rnd(wrp(hf - phf) * 8000, 3 * dt);
      rs = rnd(wrp(hs - phs) * 8000, 3 * dt);
      trpm = rnd(rud * 6144, 100);
      e0 = rf - trpm;
      e1 = rs - trpm;
      e2 = wrp(hf - tgt);
      e3 = wrp(hs - tgt);
      phf = hf; phs = hs;
      run = fill >= 2;
      if (run) begin
        p = rnd(rkp * e0, 4096);
        dd = rnd(rkd * (e1 - last_e1) * 1000, 4096 * dt);
        pd0 = sat(p + dd, PD_LIMIT);
        p = rnd(hkp * e2, 256);
        dd = rnd(hkd * wrp(e3 - last_e3) * 1000, 256 * dt);
        pd1 = sat(p + dd, PD_LIMIT);
      end
      last_e1 = e1; last_e3 = e3;
      if (fill < 3) fill++;
      if (!run) return 0;
      val = lock != 0 ? pd1 : pd0;
      if (mode == MODE_SINGLE) begin
        mv[0] = rnd(mv[0] + thr * 64, 2);
        mv[1] = rnd(mv[1] + val, 2);
      end else begin
        r = rnd(2 * mv[0] + 128 * thr + val, 4);
        l = rnd(2 * mv[1] + 128 * thr - val, 4);
        drive(r, l);
      end
      return 1;
    endfunction

    // Advance the model by one accepted poll and queue its pulse word.
    function void note_poll(poll_t w);
      longint thr, rud, tgt, turn;
      bit upd;
      pulses_t x;
      thr = sat(longint'(w.thr), 100);
      rud = sat(longint'(w.rud), 100);
      tgt = wrp(longint'(w.tgt));
      upd = 0;
      if (mode == MODE_SINGLE) begin
        if (pid == 0) begin
          mv[0] = thr * 64; mv[1] = rud * 64;
        end else begin
          upd = loop_step(w.tms, longint'(w.north), thr, rud, tgt);
        end
      end else if (mode == MODE_PAIR) begin
        if (pid == 0) begin
          turn = rnd(tgt, 180);
          drive(thr * 64 + turn, thr * 64 - turn);
        end else begin
          upd = loop_step(w.tms, longint'(w.north), thr, rud, tgt);
        end
      end
      x.fr = width_of(mv[0]); x.fl = width_of(mv[1]);
      x.rr = width_of(mv[2]); x.rl = width_of(mv[3]);
      x.upd = upd;
      pending_pulses.push_back(x);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_word(pulses_t got);
      pulses_t w;
      if (pending_pulses.size() == 0) begin
        report("pulse word with none expected");
        return;
      end
      w = pending_pulses.pop_front();
      if (got.fr !== w.fr) report($sformatf("front_right %0d exp %0d", got.fr, w.fr));
      if (got.fl !== w.fl) report($sformatf("front_left %0d exp %0d", got.fl, w.fl));
      if (got.rr !== w.rr) report($sformatf("rear_right %0d exp %0d", got.rr, w.rr));
      if (got.rl !== w.rl) report($sformatf("rear_left %0d exp %0d", got.rl, w.rl));
      if (got.upd !== w.upd) report($sformatf("loop_updated %0b exp %0b", got.upd, w.upd));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  hpm_in_if  in_ch ();
  hpm_out_if out_ch ();

  heading_pd_thruster_mixer u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch.sink),
    .out_ch    (out_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  mixer_scoreboard sb;
  int      send_idle_pct;
  int      recv_stall_pct;
  longint  cycles;
  logic [31:0] t_now;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Drive every input to a known value from time zero.
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.north_angle = '0;
    in_ch.time_ms = '0;
    in_ch.thrust_cmd = '0;
    in_ch.rudder_cmd = '0;
    in_ch.target_heading = '0;
    out_ch.ready = 1'b0;
  end

  // Timeout guard: count every cycle and give up well past the slowest run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("heading_pd_thruster_mixer_tb: done, errors");
      $finish;
    end
  end

  // Receiver: choose ready on the falling edge, check words on the rising edge.
  initial begin
    forever begin
      @(negedge clk);
      out_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    pulses_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.fr = out_ch.pulse_front_right;
      got.fl = out_ch.pulse_front_left;
      got.rr = out_ch.pulse_rear_right;
      got.rl = out_ch.pulse_rear_left;
      got.upd = out_ch.loop_updated;
      sb.check_word(got);
    end
  end

  // Offer one poll word; hold it until accepted, then note it in the model.
  task automatic send_poll(poll_t w);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.north_angle = w.north;
    in_ch.time_ms = w.tms;
    in_ch.thrust_cmd = w.thr;
    in_ch.rudder_cmd = w.rud;
    in_ch.target_heading = w.tgt;
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
      @(negedge clk);
    end
    sb.note_poll(w);
  endtask

  // Drop valid and wait until every expected word is back, then let the
  // block settle before touching its registers.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_pulses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [15:0] d);
    wait_idle();
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = d;
    @(posedge clk);
    sb.config_write(idx, d);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Build a poll; advance the clock by dt milliseconds.
  function automatic poll_t mk_poll(logic [31:0] dt, logic signed [15:0] north,
                                    logic signed [7:0] thr, logic signed [7:0] rud,
                                    logic signed [15:0] tgt);
    poll_t w;
    t_now = t_now + dt;
    w.north = north; w.tms = t_now; w.thr = thr; w.rud = rud; w.tgt = tgt;
    return w;
  endfunction

  // Random poll: mostly plausible heading motion, some raw noise.
  function automatic poll_t rand_poll();
    logic [31:0] dt;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 80) dt = $urandom_range(10, 250);
    else if (sel < 90) dt = $urandom_range(0, 9);
    else dt = $urandom;
    if ($urandom_range(0, 3) == 0)
      return mk_poll(dt, 16'($urandom), 8'($urandom), 8'($urandom), 16'($urandom));
    return mk_poll(dt, 16'($signed($urandom_range(0, 23040)) - 16'sd11520),
                   8'($signed($urandom_range(0, 220)) - 8'sd110),
                   8'($signed($urandom_range(0, 220)) - 8'sd110),
                   16'($signed($urandom_range(0, 23040)) - 16'sd11520));
  endfunction

  task automatic set_idling(int phase);
    case (phase % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
      default: begin send_idle_pct = 23; recv_stall_pct = 23; end
    endcase
  endtask

  // Random gain: extremes now and then, any value sometimes, small Q8.8 values otherwise.
  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 5))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom);
      default: return 16'($signed($urandom_range(0, 1024)) - 16'sd512);
    endcase
  endfunction

  initial begin
    int phase;
    sb = new();
    cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    t_now = 32'd100;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Open-loop pair mixing at reset defaults: field extremes and wrap edges.
    send_poll(mk_poll(0, 16'sh7FFF, 8'sd127, 8'sd127, 16'sh7FFF));
    send_poll(mk_poll(0, 16'sh8000, -8'sd128, -8'sd128, 16'sh8000));
    send_poll(mk_poll(0, 16'sd0, 8'sd0, 8'sd0, 16'sd11520));
    send_poll(mk_poll(0, 16'sd0, 8'sd100, -8'sd100, -16'sd11521));
    send_poll(mk_poll(0, 16'sd0, 8'sd0, 8'sd1, 16'sd90));

    // Single thruster by hand, then emergency rear pair, quad hold, mode 3.
    cfg_write(REG_MODE, 16'd0);
    send_poll(mk_poll(0, 16'sd0, 8'sd127, -8'sd128, 16'sd0));
    cfg_write(REG_MODE, 16'd1);
    cfg_write(REG_EMERGENCY, 16'd1);
    send_poll(mk_poll(0, 16'sd0, 8'sd50, 8'sd0, 16'sd5000));
    cfg_write(REG_MODE, 16'd2);
    send_poll(mk_poll(0, 16'sd0, -8'sd70, 8'sd20, 16'sd0));
    cfg_write(REG_MODE, 16'd3);
    send_poll(mk_poll(0, 16'sd0, 8'sd10, 8'sd20, 16'sd0));
    cfg_write(cfg_reg_t'(4'd15), 16'hFFFF);
    cfg_write(REG_MODE, 16'd1);
    cfg_write(REG_EMERGENCY, 16'd0);

    // Closed loop: latch time, short gap, filter load, history fill, then run.
    cfg_write(REG_RATE_KD, 16'd128);
    cfg_write(REG_HEAD_KD, 16'd64);
    cfg_write(REG_PID, 16'd1);
    send_poll(mk_poll(5, 16'sd640, 8'sd60, 8'sd10, 16'sd0));
    send_poll(mk_poll(3, 16'sd640, 8'sd60, 8'sd10, 16'sd0));
    send_poll(mk_poll(20, 16'sd640, 8'sd60, 8'sd10, 16'sd0));
    send_poll(mk_poll(20, 16'sd11520, 8'sd60, 8'sd10, -16'sd11520));
    send_poll(mk_poll(20, -16'sd11520, 8'sd60, 8'sd10, 16'sd3000));
    send_poll(mk_poll(20, 16'sh7FFF, 8'sd127, 8'sd127, 16'sh8000));
    send_poll(mk_poll(10, 16'sh8000, -8'sd128, -8'sd128, 16'sh7FFF));
    cfg_write(REG_LOCK, 16'd0);
    send_poll(mk_poll(9, 16'sd100, 8'sd30, 8'sd50, 16'sd0));
    send_poll(mk_poll(40, 16'sd200, 8'sd30, 8'sd50, 16'sd0));

    // Pause the sender until every word is back, then resume.
    wait_idle();

    // Random phases: fresh settings each time, extremes among them.
    for (phase = 0; phase < 8; phase++) begin
      set_idling(phase);
      cfg_write(REG_MODE, 16'($urandom_range(0, 3) == 0 ? 0 : ($urandom_range(0, 5) == 0 ?
                $urandom_range(2, 3) : 1)));
      cfg_write(REG_LOCK, 16'($urandom_range(0, 1)));
      cfg_write(REG_EMERGENCY, 16'($urandom_range(0, 1)));
      cfg_write(REG_RATE_KP, phase == 1 ? 16'h7FFF : (phase == 2 ? 16'h8000 : rand_gain()));
      cfg_write(REG_RATE_KD, phase == 1 ? 16'h8000 : (phase == 2 ? 16'h7FFF : rand_gain()));
      cfg_write(REG_HEAD_KP, phase == 3 ? 16'h7FFF : (phase == 4 ? 16'h8000 : rand_gain()));
      cfg_write(REG_HEAD_KD, phase == 3 ? 16'h8000 : (phase == 4 ? 16'h7FFF : rand_gain()));
      // Mostly closed loop; move the clock near the top so it rolls over.
      if (phase == 5) t_now = 32'hFFFF_F000;
      cfg_write(REG_PID, 16'($urandom_range(0, 5) != 0));
      repeat (46) send_poll(rand_poll());
    end

    // Drain, then give the block time to show any stray word.
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.pending_pulses.size() != 0)
      sb.report($sformatf("%0d pulse words never arrived", sb.pending_pulses.size()));
    if (sb.errors == 0) begin
      $display("heading_pd_thruster_mixer_tb: done, clean");
    end else begin
      $display("heading_pd_thruster_mixer_tb: done, errors");
    end
    $finish;
  end

endmodule
